@@ rtl/core/ack_telemetry_line_parser_macros.svh @@
`ifndef ACK_TELEMETRY_LINE_PARSER_MACROS_SVH
`define ACK_TELEMETRY_LINE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define ATLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ATLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/atlp_pkg.sv @@
package atlp_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [23:0] PAT_RR   = {CH_HASH, CH_R, CH_R};
  localparam logic [31:0] PAT_RUN  = {CH_HASH, CH_R, CH_U, CH_N};
  localparam logic [39:0] PAT_STOP = {CH_HASH, CH_S, CH_T, CH_O, CH_P};
  localparam logic [39:0] PAT_HOME = {CH_HASH, CH_H, CH_O, CH_M, CH_E};

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_RUN  = 3'd1;
  localparam logic [2:0] KIND_STOP = 3'd2;
  localparam logic [2:0] KIND_HOME = 3'd3;
  localparam logic [2:0] KIND_RATE = 3'd4;

  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] AGE_RR    = 3'd2;
  localparam logic [2:0] AGE_RUN   = 3'd3;
  localparam logic [2:0] AGE_WORD  = 3'd4;
  localparam logic [2:0] AGE_NUM   = 3'd4;
  localparam logic [2:0] AGE_RUN_D = 3'd5;
  localparam logic [2:0] AGE_WORD_D = 3'd6;
  localparam logic [2:0] AGE_MAX   = 3'd7;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] window;
    logic [2:0]  age;
    logic [2:0]  kind;
    logic [31:0] accum;
    logic [1:0]  phase;
    logic        neg;
  } state_t;

endpackage

@@ rtl/core/atlp_parse.sv @@
module atlp_parse (
  input  atlp_pkg::state_t    cur,
  input  logic [7:0]          rx_byte,
  output atlp_pkg::state_t    nxt,
  output logic                line_end,
  output logic [2:0]          ack_kind,
  output logic signed [31:0]  ack_value
);

  logic [39:0] win;
  logic        is_digit;
  logic        is_blank;
  logic [34:0] ext;
  logic [34:0] sum;
  logic [31:0] digit_acc;
  logic [2:0]  age_inc;

  always_comb begin
    win       = {cur.window, rx_byte};
    is_digit  = rx_byte inside {[8'h30:8'h39]};
    is_blank  = rx_byte inside {[8'h09:8'h0D], 8'h20};
    ext       = {3'b000, cur.accum};
    sum       = (ext << 3) + (ext << 1) + {31'd0, rx_byte[3:0]};
    digit_acc = (sum > {3'b000, atlp_pkg::MAG_LIMIT}) ? atlp_pkg::MAG_LIMIT : sum[31:0];
    age_inc   = (cur.age == atlp_pkg::AGE_MAX) ? atlp_pkg::AGE_MAX : cur.age + 3'd1;
    line_end  = (rx_byte == atlp_pkg::CH_CR);

    case (cur.kind)
      atlp_pkg::KIND_NONE: ack_value = '0;
      atlp_pkg::KIND_RATE: begin
        if (cur.neg) begin
          ack_value = -$signed(cur.accum);
        end else if (cur.accum >= atlp_pkg::MAG_LIMIT) begin
          ack_value = $signed(atlp_pkg::POS_MAX);
        end else begin
          ack_value = $signed(cur.accum);
        end
      end
      default: ack_value = $signed(cur.accum);
    endcase
    ack_kind = cur.kind;

    nxt        = cur;
    nxt.window = win[31:0];
    if (line_end) begin
      nxt = '0;
    end else if (cur.kind == atlp_pkg::KIND_NONE) begin
      if (win[23:0] == atlp_pkg::PAT_RR) begin
        nxt.kind = atlp_pkg::KIND_RATE;
        nxt.age  = atlp_pkg::AGE_RR;
      end else if (win[31:0] == atlp_pkg::PAT_RUN) begin
        nxt.kind = atlp_pkg::KIND_RUN;
        nxt.age  = atlp_pkg::AGE_RUN;
      end else if (win == atlp_pkg::PAT_STOP) begin
        nxt.kind = atlp_pkg::KIND_STOP;
        nxt.age  = atlp_pkg::AGE_WORD;
      end else if (win == atlp_pkg::PAT_HOME) begin
        nxt.kind = atlp_pkg::KIND_HOME;
        nxt.age  = atlp_pkg::AGE_WORD;
      end
    end else begin
      nxt.age = age_inc;
      if ((cur.kind == atlp_pkg::KIND_RUN && age_inc == atlp_pkg::AGE_RUN_D) ||
          ((cur.kind == atlp_pkg::KIND_STOP || cur.kind == atlp_pkg::KIND_HOME) &&
           age_inc == atlp_pkg::AGE_WORD_D)) begin
        nxt.accum = is_digit ? {28'd0, rx_byte[3:0]} : 32'd0;
      end else if (cur.kind == atlp_pkg::KIND_RATE && age_inc >= atlp_pkg::AGE_NUM) begin
        case (cur.phase)
          atlp_pkg::PH_BLANK: begin
            if (!is_blank) begin
              if (rx_byte == atlp_pkg::CH_PLUS || rx_byte == atlp_pkg::CH_MINUS) begin
                nxt.neg   = (rx_byte == atlp_pkg::CH_MINUS);
                nxt.phase = atlp_pkg::PH_SIGN;
              end else if (is_digit) begin
                nxt.accum = digit_acc;
                nxt.phase = atlp_pkg::PH_DIGIT;
              end else begin
                nxt.phase = atlp_pkg::PH_DONE;
              end
            end
          end
          atlp_pkg::PH_SIGN, atlp_pkg::PH_DIGIT: begin
            if (is_digit) begin
              nxt.accum = digit_acc;
              nxt.phase = atlp_pkg::PH_DIGIT;
            end else begin
              nxt.phase = atlp_pkg::PH_DONE;
            end
          end
          default: nxt.phase = cur.phase;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/ack_telemetry_line_parser.sv @@
// A carriage return passes from the byte register to the result register that drives out_*.
// Throughput: one byte per cycle; only a carriage return waits for a free result register.
// The byte register feeds the line state and the result register through one
// pass of parsing logic; a stalled result holds back the next carriage return, and the bytes behind it wait.
// Reset (rst_n low, synchronous): line state cleared, no transaction pending.
`include "ack_telemetry_line_parser_macros.svh"

module ack_telemetry_line_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_ack_kind,
  output logic signed [31:0] out_ack_value
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                s1_go;
  atlp_pkg::state_t    state_r;
  atlp_pkg::state_t    state_nxt;
  logic                line_end;
  logic [2:0]          res_kind;
  logic signed [31:0]  res_value;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [2:0]          out_kind_r;
  logic signed [31:0]  out_value_r;

  atlp_parse u_parse (
    .cur       (state_r),
    .rx_byte   (s1_byte_r),
    .nxt       (state_nxt),
    .line_end  (line_end),
    .ack_kind  (res_kind),
    .ack_value (res_value)
  );

  assign s1_go    = s1_valid_r & (!line_end | !out_valid_r | !out_stall);
  assign in_stall = s1_valid_r & !s1_go;

  always_comb begin
    s1_valid_nxt = (in_valid & !in_stall) | (s1_valid_r & !s1_go);
    if (s1_go && line_end) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_go && line_end) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ack_kind  = out_kind_r;
  assign out_ack_value = out_value_r;

  `ATLP_ASSERT(a_none_zero, clk, rst_n,
    out_valid_r && out_kind_r == atlp_pkg::KIND_NONE |-> out_value_r == 32'sd0,
    "kind none with nonzero value")
  `ATLP_ASSERT(a_line_clear, clk, rst_n,
    s1_go && line_end |=> state_r.kind == atlp_pkg::KIND_NONE && state_r.window == 32'd0,
    "line state not cleared at carriage return")
  `ATLP_ASSERT(a_mag_limit, clk, rst_n,
    state_r.accum <= atlp_pkg::MAG_LIMIT,
    "number magnitude above limit")
  `ATLP_ASSERT(a_ack_digit, clk, rst_n,
    state_r.kind == atlp_pkg::KIND_RUN || state_r.kind == atlp_pkg::KIND_STOP ||
    state_r.kind == atlp_pkg::KIND_HOME |-> state_r.accum <= 32'd9,
    "ack digit out of range")
  `ATLP_ASSERT(a_out_source, clk, rst_n,
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_byte_r == atlp_pkg::CH_CR),
    "result without carriage return")

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } ack_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_ack_kind;
  logic signed [31:0] out_ack_value;

  ack_t ack_q[$];
  ack_t ack_head;
  int   mismatches = 0;
  int   bytes_sent = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  logic [47:0] ln_window = '0;
  logic [7:0]  ln_age = '0;
  logic [2:0]  ln_kind = atlp_pkg::KIND_NONE;
  logic [31:0] ln_accum = '0;
  logic [1:0]  ln_phase = atlp_pkg::PH_BLANK;
  logic        ln_neg = 1'b0;

  ack_telemetry_line_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ack_kind (out_ack_kind),
    .out_ack_value(out_ack_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] decimal_step(input logic [31:0] acc, input logic [7:0] c);
    logic [63:0] v;
    v = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
    return (v > {32'd0, atlp_pkg::MAG_LIMIT}) ? atlp_pkg::MAG_LIMIT : v[31:0];
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == atlp_pkg::CH_CR) b = atlp_pkg::CH_HASH;
    return b;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] c);
    ack_t ack;
    if (c == atlp_pkg::CH_CR) begin
      ack.kind = ln_kind;
      if (ln_kind == atlp_pkg::KIND_RATE) begin
        if (ln_neg) ack.value = 32'd0 - ln_accum;
        else ack.value = (ln_accum >= atlp_pkg::MAG_LIMIT) ? atlp_pkg::POS_MAX : ln_accum;
      end else if (ln_kind == atlp_pkg::KIND_NONE) begin
        ack.value = '0;
      end else begin
        ack.value = ln_accum;
      end
      ack_q.push_back(ack);
      ln_window = '0;
      ln_age = '0;
      ln_kind = atlp_pkg::KIND_NONE;
      ln_accum = '0;
      ln_phase = atlp_pkg::PH_BLANK;
      ln_neg = 1'b0;
      return;
    end
    ln_window = {ln_window[39:0], c};
    if (ln_kind == atlp_pkg::KIND_NONE) begin
      if (ln_window[23:0] == atlp_pkg::PAT_RR) begin
        ln_kind = atlp_pkg::KIND_RATE;
        ln_age = 8'(atlp_pkg::AGE_RR);
      end else if (ln_window[31:0] == atlp_pkg::PAT_RUN) begin
        ln_kind = atlp_pkg::KIND_RUN;
        ln_age = 8'(atlp_pkg::AGE_RUN);
      end else if (ln_window[39:0] == atlp_pkg::PAT_STOP) begin
        ln_kind = atlp_pkg::KIND_STOP;
        ln_age = 8'(atlp_pkg::AGE_WORD);
      end else if (ln_window[39:0] == atlp_pkg::PAT_HOME) begin
        ln_kind = atlp_pkg::KIND_HOME;
        ln_age = 8'(atlp_pkg::AGE_WORD);
      end
      return;
    end
    if (ln_age != 8'hFF) ln_age++;
    if ((ln_kind == atlp_pkg::KIND_RUN && ln_age == 8'(atlp_pkg::AGE_RUN_D)) ||
        ((ln_kind == atlp_pkg::KIND_STOP || ln_kind == atlp_pkg::KIND_HOME) &&
         ln_age == 8'(atlp_pkg::AGE_WORD_D))) begin
      ln_accum = is_digit(c) ? {24'd0, c - CH_ZERO} : '0;
    end else if (ln_kind == atlp_pkg::KIND_RATE && ln_age >= 8'(atlp_pkg::AGE_NUM)) begin
      case (ln_phase)
        atlp_pkg::PH_BLANK: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= atlp_pkg::CH_CR)) begin
          end else if (c == atlp_pkg::CH_PLUS || c == atlp_pkg::CH_MINUS) begin
            ln_neg = (c == atlp_pkg::CH_MINUS);
            ln_phase = atlp_pkg::PH_SIGN;
          end else if (is_digit(c)) begin
            ln_accum = decimal_step(ln_accum, c);
            ln_phase = atlp_pkg::PH_DIGIT;
          end else begin
            ln_phase = atlp_pkg::PH_DONE;
          end
        end
        atlp_pkg::PH_SIGN, atlp_pkg::PH_DIGIT: begin
          if (is_digit(c)) begin
            ln_accum = decimal_step(ln_accum, c);
            ln_phase = atlp_pkg::PH_DIGIT;
          end else begin
            ln_phase = atlp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) parse_rx_byte(in_rx_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ack_q.size() == 0) begin
        report_mismatch($sformatf("kind %0d value %0d with no line end pending",
                                  out_ack_kind, out_ack_value));
      end else begin
        ack_head = ack_q.pop_front();
        if (out_ack_kind !== ack_head.kind)
          report_mismatch($sformatf("ack_kind got %0d expected %0d",
                                    out_ack_kind, ack_head.kind));
        if (out_ack_value !== ack_head.value)
          report_mismatch($sformatf("ack_value got %0d expected %0d",
                                    out_ack_value, $signed(ack_head.value)));
      end
    end
  end

  // hold off the result channel for a counted stretch when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(atlp_pkg::CH_CR);
  endtask

  task automatic send_ack_digit();
    if ($urandom_range(0, 9) == 0) return;
    send_byte(noise_byte());
    if ($urandom_range(0, 9) == 0) return;
    if ($urandom_range(0, 4) != 0) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    else send_byte(noise_byte());
  endtask

  task automatic send_rate_number();
    int n;
    if ($urandom_range(0, 9) == 0) return;
    send_byte(noise_byte());
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: send_text("2147483647");
        1: send_text("2147483648");
        2: send_text("-2147483648");
        default: send_text("-2147483649");
      endcase
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) == 0) send_byte(CH_SPACE);
      else send_byte(8'($urandom_range(CH_TAB, CH_FF)));
    end
    case ($urandom_range(0, 3))
      0: send_byte(atlp_pkg::CH_PLUS);
      1: send_byte(atlp_pkg::CH_MINUS);
      default: begin
      end
    endcase
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (n) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
  endtask

  task automatic send_random_line();
    repeat ($urandom_range(0, 3)) send_byte(noise_byte());
    case ($urandom_range(0, 9))
      0, 1: begin
        send_text("#RUN");
        send_ack_digit();
      end
      2: begin
        send_text("#STOP");
        send_ack_digit();
      end
      3: begin
        send_text("#HOME");
        send_ack_digit();
      end
      4, 5, 6, 7: begin
        send_text("#RR");
        send_rate_number();
      end
      8: begin
        send_text("#R");
        send_byte(noise_byte());
        send_text("#STOP");
        send_ack_digit();
      end
      default: repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    endcase
    repeat ($urandom_range(0, 3)) send_byte(noise_byte());
    send_byte(atlp_pkg::CH_CR);
  endtask

  task automatic test_ack_tags();
    send_line("#RUN 7");
    send_line("#STOP:0");
    send_line("#HOME 9x");
    send_line("#HOME x");
    send_line("#STOP");
    send_line("a#R#RUN:3#RR 5");
  endtask

  task automatic test_rate_numbers();
    send_line("#RR:123");
    send_line("#RR: \t-42x7");
    send_line("#RR:+");
    send_line("#RR:99999999999");
    send_line("#RR:2147483647");
    send_line("#RR:-2147483649");
    send_line("#RR:");
    send_text("#RR:");
    send_byte(CH_LF);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_line("+8");
  endtask

  task automatic test_line_edges();
    send_byte(atlp_pkg::CH_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("#RU");
    send_line("N 5");
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int budget);
    int first_byte;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < budget) send_random_line();
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_left = 200;
    repeat (4) send_line("#HOME 2");
    repeat (4) send_random_line();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ack_tags();
    test_rate_numbers();
    test_line_edges();
    test_random_traffic(0, 0, 125);
    test_random_traffic(71, 0, 125);
    test_random_traffic(0, 71, 125);
    test_random_traffic(34, 34, 125);
    test_backpressure();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (ack_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
